// File: hw/rtl/prime_filter_trial_division_macros.svh
// ---------------------------------------------------------------------------
// prime filter assertion macros
// same-cycle and next-cycle implication checks for the prime filter
// ---------------------------------------------------------------------------
`ifndef PRIME_FILTER_TRIAL_DIVISION_MACROS_SVH
`define PRIME_FILTER_TRIAL_DIVISION_MACROS_SVH

// consequent holds in the same cycle
`define PFTD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pftd check failed");

// consequent holds in the cycle after the antecedent
`define PFTD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pftd check failed");

`endif

// File: hw/rtl/pftd_pkg.sv
// ---------------------------------------------------------------------------
// pftd_pkg
// types, constants and microcode table of the prime filter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pftd_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH     = 32;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef enum logic [3:0] {
		ST_FETCH    = 4'd0,
		ST_CLASSIFY = 4'd1,
		ST_SMALL    = 4'd2,
		ST_DIVSTART = 4'd3,
		ST_DIVSTEP  = 4'd4,
		ST_CHECK    = 4'd5,
		ST_BOUND    = 4'd6,
		ST_PRIME    = 4'd7,
		ST_KEEP     = 4'd8,
		ST_END      = 4'd9
	} step_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIV_START,
		OP_DIV_STEP,
		OP_ADVANCE,
		OP_EMIT_KEEP,
		OP_EMIT_END
	} op_t;

	typedef enum logic [3:0] {
		C_ALWAYS,
		C_IN_ACCEPT,
		C_TRIVIAL_KEEP,
		C_PRIME_EARLY,
		C_DIV_MORE,
		C_REM_ZERO,
		C_SQ_LE_N,
		C_LAST,
		C_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jt;
		step_t jf;
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		unique case (s)
			ST_FETCH:    w = '{OP_LOAD,      C_IN_ACCEPT,    ST_CLASSIFY, ST_FETCH};
			ST_CLASSIFY: w = '{OP_NONE,      C_TRIVIAL_KEEP, ST_KEEP,     ST_SMALL};
			ST_SMALL:    w = '{OP_NONE,      C_PRIME_EARLY,  ST_PRIME,    ST_DIVSTART};
			ST_DIVSTART: w = '{OP_DIV_START, C_ALWAYS,       ST_DIVSTEP,  ST_DIVSTEP};
			ST_DIVSTEP:  w = '{OP_DIV_STEP,  C_DIV_MORE,     ST_DIVSTEP,  ST_CHECK};
			ST_CHECK:    w = '{OP_ADVANCE,   C_REM_ZERO,     ST_KEEP,     ST_BOUND};
			ST_BOUND:    w = '{OP_NONE,      C_SQ_LE_N,      ST_DIVSTART, ST_PRIME};
			ST_PRIME:    w = '{OP_NONE,      C_LAST,         ST_END,      ST_FETCH};
			ST_KEEP:     w = '{OP_EMIT_KEEP, C_OUT_FREE,     ST_FETCH,    ST_KEEP};
			ST_END:      w = '{OP_EMIT_END,  C_OUT_FREE,     ST_FETCH,    ST_END};
			default:     w = '{OP_NONE,      C_ALWAYS,       ST_FETCH,    ST_FETCH};
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/prime_filter_trial_division.sv
// ---------------------------------------------------------------------------
// prime_filter_trial_division
// drops primes from a stream of signed values, passes the rest with a count
// ---------------------------------------------------------------------------
// channel  | ports      | payload
// in       | s_axis_*   | tdata: value; tlast: last
// out      | m_axis_*   | tdata: kept_value, kept_count; tuser: has_value;
//          |            | tlast: end_of_array
//
// an item is settled without division in the classify or small-value step, or else
// odd divisors are tried one after another (bit-serial remainder unit)
// async reset clears the sequencer, the kept count and the output valid
// one item is in work at a time; a waiting result does not hold up the next
// item until that item itself has a result to place
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "prime_filter_trial_division_macros.svh"

module prime_filter_trial_division #(
	parameter int VALUE_WIDTH = pftd_pkg::VALUE_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         s_axis_tvalid,
	output logic                                         s_axis_tready,
	// value
	input  logic [((VALUE_WIDTH+7)/8)*8-1:0]             s_axis_tdata,
	input  logic                                         s_axis_tlast,
	output logic                                         m_axis_tvalid,
	input  logic                                         m_axis_tready,
	// kept_value, kept_count
	output logic [((VALUE_WIDTH+pftd_pkg::COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	// has_value
	output logic                                         m_axis_tuser,
	output logic                                         m_axis_tlast
);
	import pftd_pkg::*;

	localparam int OUT_DATA_W = ((VALUE_WIDTH + COUNT_WIDTH + 7) / 8) * 8;
	localparam int BIT_W      = $clog2(VALUE_WIDTH);
	localparam int SQ_W       = VALUE_WIDTH + 2;

	step_t  step_q, step_d;
	ucode_t uc;
	logic   cond_true;

	logic [VALUE_WIDTH-1:0] n_q;
	logic                   last_q;
	logic [VALUE_WIDTH-1:0] d_q;
	logic [SQ_W-1:0]        sq_q;
	logic [VALUE_WIDTH-1:0] rem_q;
	logic [BIT_W-1:0]       bit_q;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic                   out_has_q;
	logic                   out_last_q;
	logic [COUNT_WIDTH-1:0] out_count_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic                   in_accept;
	logic                   out_free;
	logic                   trivial_keep;
	logic                   prime_early;
	logic                   sq_le_n;
	logic [VALUE_WIDTH:0]   rem_sh;
	logic [VALUE_WIDTH:0]   rem_sub;
	logic [COUNT_WIDTH-1:0] count_inc;
	logic                   emit_keep;
	logic                   emit_end;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	assign trivial_keep = n_q[VALUE_WIDTH-1] || (n_q <= VALUE_WIDTH'(1)) ||
		(!n_q[0] && (n_q != VALUE_WIDTH'(2)));
	assign sq_le_n      = sq_q <= SQ_W'(n_q);
	assign prime_early  = (n_q == VALUE_WIDTH'(2)) || !sq_le_n;

	// one restoring step of n mod d
	assign rem_sh  = {rem_q, n_q[bit_q]};
	assign rem_sub = rem_sh - {1'b0, d_q};

	assign count_inc = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_WIDTH'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_FETCH;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		uc = ucode_rom(step_q);
		unique case (uc.cond)
			C_ALWAYS:       cond_true = 1'b1;
			C_IN_ACCEPT:    cond_true = in_accept;
			C_TRIVIAL_KEEP: cond_true = trivial_keep;
			C_PRIME_EARLY:  cond_true = prime_early;
			C_DIV_MORE:     cond_true = bit_q != '0;
			C_REM_ZERO:     cond_true = rem_q == '0;
			C_SQ_LE_N:      cond_true = sq_le_n;
			C_LAST:         cond_true = last_q;
			C_OUT_FREE:     cond_true = out_free;
			default:        cond_true = 1'b0;
		endcase
		step_d        = cond_true ? uc.jt : uc.jf;
		s_axis_tready = uc.op == OP_LOAD;
		emit_keep     = (uc.op == OP_EMIT_KEEP) && out_free;
		emit_end      = (uc.op == OP_EMIT_END) && out_free;
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (uc.op)
			OP_LOAD: begin
				if (in_accept) begin
					n_q    <= s_axis_tdata[VALUE_WIDTH-1:0];
					last_q <= s_axis_tlast;
					d_q    <= VALUE_WIDTH'(3);
					sq_q   <= SQ_W'(9);
				end
			end
			OP_DIV_START: begin
				rem_q <= '0;
				bit_q <= BIT_W'(VALUE_WIDTH - 1);
			end
			OP_DIV_STEP: begin
				rem_q <= rem_sub[VALUE_WIDTH] ? rem_sh[VALUE_WIDTH-1:0]
					: rem_sub[VALUE_WIDTH-1:0];
				bit_q <= bit_q - BIT_W'(1);
			end
			OP_ADVANCE: begin
				// (d+2)^2 = d^2 + 4d + 4
				d_q  <= d_q + VALUE_WIDTH'(2);
				sq_q <= sq_q + {d_q, 2'b00} + SQ_W'(4);
			end
			default: begin
			end
		endcase
	end

	// output register and kept count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
		end else begin
			if (emit_keep || emit_end) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (emit_keep) begin
				count_q <= last_q ? '0 : count_inc;
			end else if (emit_end) begin
				count_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_keep) begin
			out_value_q <= n_q;
			out_has_q   <= 1'b1;
			out_last_q  <= last_q;
			out_count_q <= count_inc;
		end else if (emit_end) begin
			out_value_q <= '0;
			out_has_q   <= 1'b0;
			out_last_q  <= 1'b1;
			out_count_q <= count_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_count_q, out_value_q});
	assign m_axis_tuser  = out_has_q;
	assign m_axis_tlast  = out_last_q;

	`PFTD_ASSERT_NOW(a_marker_is_end, clk, arst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
	`PFTD_ASSERT_NOW(a_kept_counted, clk, arst_n, m_axis_tvalid && m_axis_tuser,
		m_axis_tdata[VALUE_WIDTH+COUNT_WIDTH-1:VALUE_WIDTH] != '0)
	`PFTD_ASSERT_NEXT(a_count_clears, clk, arst_n, (emit_keep || emit_end) && last_q,
		count_q == '0)
	`PFTD_ASSERT_NOW(a_divisor_odd, clk, arst_n, step_q == ST_DIVSTEP,
		d_q[0] && (d_q >= VALUE_WIDTH'(3)))

endmodule

// File: sim/tb_prime_filter_trial_division.sv
// ---------------------------------------------------------------------------
// tb_prime_filter_trial_division
// self-checking stream test of the trial-division prime filter: a queue-fed
// driver offers signed values, an independent predictor of the primality
// test and the kept count builds the expected results, and a monitor checks
// every output item field by field under several idle and stall patterns
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_prime_filter_trial_division;

	localparam int VALUE_W      = pftd_pkg::VALUE_WIDTH_DEF;
	localparam int CNT_W        = pftd_pkg::COUNT_WIDTH;
	localparam int IN_W         = ((VALUE_W + 7) / 8) * 8;
	localparam int OUT_W        = ((VALUE_W + CNT_W + 7) / 8) * 8;
	localparam int MAX_TRIES    = 64;
	localparam int LONG_HOLD    = 400;
	localparam int TAIL_CYCLES  = 3000;
	localparam int TIMEOUT_NS   = 50_000_000;
	localparam int NUM_PHASES   = 5;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               drain_first;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] kept_value;
		logic               has_value;
		logic               end_of_array;
		logic [CNT_W-1:0]   kept_count;
	} kept_item_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic             s_axis_tlast = 1'b0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic             m_axis_tuser;
	logic             m_axis_tlast;

	in_item_t   values_to_send[$];
	kept_item_t expected_kept[$];
	logic [CNT_W-1:0] kept_tally = '0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         phase_id = 0;
	logic       rx_hold = 1'b0;
	int         error_count = 0;
	in_item_t   next_item;
	kept_item_t got_item;
	kept_item_t want_item;

	prime_filter_trial_division #(
		.VALUE_WIDTH(VALUE_W)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// trial division with odd divisors while div <= v / div
	function automatic bit is_prime_value(input logic [VALUE_W-1:0] v, output int tries);
		logic [VALUE_W-1:0] div;
		tries = 0;
		if (v[VALUE_W-1] || v <= 1)
			return 1'b0;
		if (v == 2)
			return 1'b1;
		if (!v[0])
			return 1'b0;
		for (div = 3; div <= v / div; div += 2) begin
			tries++;
			if (v % div == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic predict_filter(input logic [VALUE_W-1:0] v, input logic last);
		kept_item_t res;
		int tries;
		if (!is_prime_value(v, tries)) begin
			if (kept_tally != pftd_pkg::COUNT_MAX)
				kept_tally = kept_tally + 1'b1;
			res = '{kept_value: v, has_value: 1'b1, end_of_array: last, kept_count: kept_tally};
			expected_kept.push_back(res);
			if (last)
				kept_tally = '0;
		end else if (last) begin
			res = '{kept_value: '0, has_value: 1'b0, end_of_array: 1'b1, kept_count: kept_tally};
			expected_kept.push_back(res);
			kept_tally = '0;
		end
	endtask

	// mostly cheap values; wide random odd values that need long division are made even
	function automatic logic [VALUE_W-1:0] random_value();
		int pick;
		int tries;
		logic [VALUE_W-1:0] v;
		pick = $urandom_range(99);
		if (pick < 45) begin
			v = $urandom_range(260) - 20;
		end else if (pick < 65) begin
			v = (2 * $urandom_range(1, 49) + 1) * (2 * $urandom_range(0, 49) + 1);
		end else if (pick < 80) begin
			v = $urandom_range(4000) | 1;
		end else begin
			v = $urandom();
			void'(is_prime_value(v, tries));
			if (tries > MAX_TRIES)
				v[0] = 1'b0;
		end
		return v;
	endfunction

	task automatic queue_item(input logic [VALUE_W-1:0] v, input logic last,
		input logic drain);
		in_item_t it;
		it = '{value: v, last: last, drain_first: drain};
		values_to_send.push_back(it);
	endtask

	task automatic log_error(input string msg);
		error_count++;
		if (error_count <= 10)
			$display("error: %s", msg);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tlast <= 1'b0;
			kept_tally = '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				predict_filter(s_axis_tdata[VALUE_W-1:0], s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (values_to_send.size() > 0 &&
					!(values_to_send[0].drain_first && expected_kept.size() > 0) &&
					$urandom_range(99) >= send_idle_pct) begin
					next_item = values_to_send.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= IN_W'(next_item.value);
					s_axis_tlast <= next_item.last;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_item.kept_value = m_axis_tdata[VALUE_W-1:0];
				got_item.kept_count = m_axis_tdata[VALUE_W +: CNT_W];
				got_item.has_value = m_axis_tuser;
				got_item.end_of_array = m_axis_tlast;
				if (expected_kept.size() == 0) begin
					log_error($sformatf("unexpected item value %0d has %0b end %0b count %0d",
						$signed(got_item.kept_value), got_item.has_value,
						got_item.end_of_array, got_item.kept_count));
				end else begin
					want_item = expected_kept.pop_front();
					if (got_item.kept_value !== want_item.kept_value ||
						got_item.has_value !== want_item.has_value ||
						got_item.end_of_array !== want_item.end_of_array ||
						got_item.kept_count !== want_item.kept_count)
						log_error($sformatf({"expected value %0d has %0b end %0b count %0d, ",
							"got value %0d has %0b end %0b count %0d"},
							$signed(want_item.kept_value), want_item.has_value,
							want_item.end_of_array, want_item.kept_count,
							$signed(got_item.kept_value), got_item.has_value,
							got_item.end_of_array, got_item.kept_count));
				end
			end
			m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off while the sender keeps going
	initial begin
		while (phase_id != 1)
			@(negedge clk);
		rx_hold = 1'b1;
		repeat (LONG_HOLD) @(posedge clk);
		@(negedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int n_items;
		int i;
		int ph;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, squares, dropped primes, end-only markers
		queue_item(0, 1'b0, 1'b0);
		queue_item(1, 1'b0, 1'b0);
		queue_item(2, 1'b0, 1'b0);
		queue_item(3, 1'b0, 1'b0);
		queue_item(4, 1'b0, 1'b0);
		queue_item(9, 1'b0, 1'b0);
		queue_item(25, 1'b0, 1'b0);
		queue_item(49, 1'b0, 1'b0);
		queue_item(15, 1'b0, 1'b0);
		queue_item(17, 1'b0, 1'b0);
		queue_item(-1, 1'b0, 1'b0);
		queue_item(32'h8000_0000, 1'b0, 1'b0);
		queue_item(32'h7fff_fffe, 1'b0, 1'b0);
		queue_item(32'h7fff_fffd, 1'b0, 1'b0);
		queue_item(32'h5555_5555, 1'b0, 1'b0);
		queue_item(32'haaaa_aaaa, 1'b0, 1'b0);
		queue_item(1000003, 1'b0, 1'b0);
		queue_item(1018081, 1'b0, 1'b0);
		queue_item(999983, 1'b1, 1'b0);
		queue_item(8, 1'b1, 1'b0);
		queue_item(7, 1'b1, 1'b1);
		queue_item(2, 1'b1, 1'b0);
		queue_item(121, 1'b0, 1'b0);
		queue_item(11, 1'b1, 1'b0);

		for (ph = 1; ph < NUM_PHASES; ph++) begin
			while (values_to_send.size() > 0)
				@(negedge clk);
			case (ph)
				1: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 74;
					recv_stall_pct = 0;
				end
				3: begin
					send_idle_pct = 0;
					recv_stall_pct = 74;
				end
				default: begin
					send_idle_pct = 18;
					recv_stall_pct = 18;
				end
			endcase
			n_items = (ph == 1) ? 40 : 28;
			for (i = 0; i < n_items; i++)
				queue_item(random_value(),
					(ph == NUM_PHASES - 1 && i == n_items - 1) || $urandom_range(7) == 0,
					i == 0 && ph > 1);
			phase_id = ph;
		end

		while (values_to_send.size() > 0 || s_axis_tvalid || expected_kept.size() > 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
